### hw/rtl/dpcp_pkg.sv
// ----------------------------------------------------------------------------
// dpcp_pkg
// Shared types and constants for the diagnostic page counter parser: byte
// positions of the page header, byte classes, status codes and queue item.
// ----------------------------------------------------------------------------
package dpcp_pkg;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_PAGE_CODE = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd3;
    localparam logic [POS_W-1:0] POS_FC_HI     = 17'd16;
    localparam logic [POS_W-1:0] POS_FC_LO     = 17'd17;
    localparam logic [POS_W-1:0] POS_FID_HI    = 17'd18;
    localparam logic [POS_W-1:0] POS_FID_LO    = 17'd19;
    localparam logic [POS_W-1:0] POS_PC_HI     = 17'd23;
    localparam logic [POS_W-1:0] POS_PC_LO     = 17'd24;
    localparam logic [POS_W-1:0] POS_FIRST_REC = 17'd26;

    localparam logic [15:0] HDR_BYTES_AFTER_LEN = 16'd22;
    localparam logic [16:0] LEN_OVERHEAD        = 17'd4;
    localparam logic [15:0] MAX_COUNTER_ID      = 16'd5;
    localparam logic [7:0]  EXP_PAGE_RESET      = 8'h82;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        K_SKIP,
        K_PAGE,
        K_LEN_HI,
        K_LEN_LO,
        K_FC_HI,
        K_FC_LO,
        K_FID,
        K_PC_HI,
        K_PC_LO,
        K_REC
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_PAGE     = 3'd2,
        ST_FCOUNT   = 3'd3,
        ST_FID      = 3'd4,
        ST_RESIDUAL = 3'd5
    } t_status;

    // One classified byte on its way from the front to the back
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic             last;
        logic             short_page;  // page ended before the feature count completed
        logic [POS_W-1:0] count;       // saturated byte count including this byte
    } t_item;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

### hw/rtl/dpcp_front.sv
// ----------------------------------------------------------------------------
// dpcp_front
// Byte position tracker: accepts page bytes, classifies each by position and
// pushes it into the queue.
// ----------------------------------------------------------------------------
module dpcp_front import dpcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_full,
    output t_push      o_push
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] cnt;
    logic             accept;
    t_kind            kind;

    assign accept = i_in_valid && !i_full;
    assign cnt    = (r_pos == POS_MAX) ? r_pos : r_pos + 17'd1;

    always_comb begin
        unique case (r_pos)
            POS_PAGE_CODE:          kind = K_PAGE;
            POS_LEN_HI:             kind = K_LEN_HI;
            POS_LEN_LO:             kind = K_LEN_LO;
            POS_FC_HI:              kind = K_FC_HI;
            POS_FC_LO:              kind = K_FC_LO;
            POS_FID_HI, POS_FID_LO: kind = K_FID;
            POS_PC_HI:              kind = K_PC_HI;
            POS_PC_LO:              kind = K_PC_LO;
            default:                kind = (r_pos >= POS_FIRST_REC) ? K_REC : K_SKIP;
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = i_last_byte ? '0 : cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_push.push            = accept;
    assign o_push.item.kind       = kind;
    assign o_push.item.data       = i_data_byte;
    assign o_push.item.last       = i_last_byte;
    assign o_push.item.short_page = (r_pos < POS_FC_LO);
    assign o_push.item.count      = cnt;

endmodule

### hw/rtl/dpcp_fifo.sv
// ----------------------------------------------------------------------------
// dpcp_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module dpcp_fifo import dpcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full       = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != FIFO_CW'(FIFO_DEPTH) && r_count != '0) |->
            (r_wr_ptr - r_rd_ptr) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> r_count == $past(r_count) - FIFO_CW'(1))
        else $error("pop did not drain the queue");

endmodule

### hw/rtl/dpcp_back.sv
// ----------------------------------------------------------------------------
// dpcp_back
// Field assembly and page checks: applies each classified byte, builds the
// counter records, and registers one result per completed recognized counter
// record or page end.
module dpcp_back import dpcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  t_head       i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_update_valid,
    output logic [3:0]  o_target,
    output logic [31:0] o_value,
    output logic        o_done_res,
    output logic [2:0]  o_status
);

    logic [7:0]  r_expected;
    logic [15:0] r_length,   n_length;
    logic [7:0]  r_page,     n_page;
    logic [15:0] r_params,   n_params;
    logic [2:0]  r_rec_idx,  n_rec_idx;
    logic [15:0] r_param_id, n_param_id;
    logic [15:0] r_port,     n_port;
    logic [31:0] r_value,    n_value;
    logic [15:0] r_residual, n_residual;
    t_status     r_first_err, n_first_err;

    logic        r_out_valid;
    logic        r_out_upd;
    logic [3:0]  r_out_target;
    logic [31:0] r_out_value;
    logic        r_out_done;
    logic [2:0]  r_out_status;

    logic        ready;
    logic        last;
    logic        upd;
    logic [3:0]  tgt;
    logic [31:0] val;
    t_status     st;
    t_status     err_code;
    t_item       it;

    assign it          = i_head.item;
    assign ready       = !r_out_valid || !i_out_stall;
    assign o_pop       = i_head.valid && ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_length    = r_length;
        n_page      = r_page;
        n_params    = r_params;
        n_rec_idx   = r_rec_idx;
        n_param_id  = r_param_id;
        n_port      = r_port;
        n_value     = r_value;
        n_residual  = r_residual;
        n_first_err = r_first_err;
        err_code    = ST_OK;
        upd         = 1'b0;
        tgt         = 4'd0;
        val         = 32'd0;
        st          = ST_OK;
        last        = o_pop && it.last;

        if (o_pop) begin
            unique case (it.kind)
                K_PAGE:   n_page = it.data;
                K_LEN_HI: n_length = {it.data, 8'h00};
                K_LEN_LO: begin
                    n_length   = r_length | {8'h00, it.data};
                    n_residual = n_length - HDR_BYTES_AFTER_LEN;
                end
                K_FC_HI:  if (it.data != 8'd0) err_code = ST_FCOUNT;
                K_FC_LO:  if (it.data != 8'd1) err_code = ST_FCOUNT;
                K_FID:    if (it.data != 8'd0) err_code = ST_FID;
                K_PC_HI: begin
                    n_params   = {it.data, 8'h00};
                    n_residual = r_residual - {it.data[4:0], 11'd0};
                end
                K_PC_LO: begin
                    n_params   = r_params | {8'h00, it.data};
                    n_residual = r_residual - {5'd0, it.data, 3'd0};
                end
                K_REC: begin
                    if (r_params != 16'd0) begin
                        unique case (r_rec_idx)
                            3'd0:    n_param_id = {it.data, 8'h00};
                            3'd1:    n_param_id = r_param_id | {8'h00, it.data};
                            3'd2:    n_port = {it.data, 8'h00};
                            3'd3:    n_port = r_port | {8'h00, it.data};
                            3'd4:    n_value = {24'd0, it.data};
                            default: n_value = {r_value[23:0], it.data};
                        endcase
                        if (r_rec_idx == 3'd7) begin
                            // report only known counters of a page that looks right so far
                            if (r_page == r_expected && r_first_err == ST_OK) begin
                                if (r_param_id == 16'd0 && r_port == 16'd0) begin
                                    upd = 1'b1;
                                end else if (r_param_id != 16'd0 &&
                                             r_param_id <= MAX_COUNTER_ID &&
                                             r_port <= 16'd1) begin
                                    upd = 1'b1;
                                    tgt = {r_param_id[2:0], 1'b0} - 4'd1 + {3'd0, r_port[0]};
                                end
                            end
                            if (upd) begin
                                val = n_value;
                            end
                            n_params  = r_params - 16'd1;
                            n_rec_idx = 3'd0;
                        end else begin
                            n_rec_idx = r_rec_idx + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (err_code != ST_OK && r_first_err == ST_OK) begin
            n_first_err = err_code;
        end

        if (last) begin
            if (it.count != ({1'b0, n_length} + LEN_OVERHEAD)) begin
                st = ST_LENGTH;
            end else if (n_page != r_expected) begin
                st = ST_PAGE;
            end else if (it.short_page || n_first_err == ST_FCOUNT) begin
                st = ST_FCOUNT;
            end else if (n_first_err != ST_OK) begin
                st = n_first_err;
            end else if (n_residual != 16'd0) begin
                st = ST_RESIDUAL;
            end
            // clear for the next page
            n_length    = '0;
            n_page      = '0;
            n_params    = '0;
            n_rec_idx   = '0;
            n_param_id  = '0;
            n_port      = '0;
            n_value     = '0;
            n_residual  = '0;
            n_first_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= EXP_PAGE_RESET;
            r_length    <= '0;
            r_page      <= '0;
            r_params    <= '0;
            r_rec_idx   <= '0;
            r_param_id  <= '0;
            r_port      <= '0;
            r_value     <= '0;
            r_residual  <= '0;
            r_first_err <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_expected <= i_cfg_data;
            end
            r_length    <= n_length;
            r_page      <= n_page;
            r_params    <= n_params;
            r_rec_idx   <= n_rec_idx;
            r_param_id  <= n_param_id;
            r_port      <= n_port;
            r_value     <= n_value;
            r_residual  <= n_residual;
            r_first_err <= n_first_err;
            if (ready) begin
                r_out_valid <= upd || last;
            end
        end
    end

    // Hold the payload while the output transaction waits
    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_out_upd    <= upd;
            r_out_target <= tgt;
            r_out_value  <= val;
            r_out_done   <= last;
            r_out_status <= st;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_update_valid = r_out_upd;
    assign o_target       = r_out_target;
    assign o_value        = r_out_value;
    assign o_done_res     = r_out_done;
    assign o_status       = r_out_status;

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_upd || r_out_done))
        else $error("result without update or page end");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_done || r_out_status == ST_OK) &&
                         (r_out_upd || (r_out_target == 4'd0 && r_out_value == 32'd0))))
        else $error("meaningless result fields not zero");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_upd) |-> r_out_target <= 4'd10)
        else $error("counter target out of range");

    a_rec_idx_needs_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_idx != 3'd0) |-> (r_params != 16'd0))
        else $error("record in progress with no records left");

endmodule

### hw/rtl/diag_page_counter_parser.sv
// ----------------------------------------------------------------------------
// diag_page_counter_parser
// Receive-diagnostic page parser reporting link counter records and a page
// status.
// ----------------------------------------------------------------------------
// Takes one page byte per cycle while the queue is not full. A front
// stage tracks the byte position and classifies each byte; a 4-entry queue
// feeds a back stage that assembles header fields and 8-byte records and
// registers one result per completed recognized counter record or per last
// byte. An accepted byte is written into the queue; the back stage pops it
// and registers its result. The queue absorbs output stalls, and the
// input stalls only when the queue is full. Counter updates are provisional:
// the page status on the last byte's result says whether the length check
// passed. The page code register (reset 0x82) may be written only while idle.
module diag_page_counter_parser import dpcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_update_valid,
    output logic [3:0]  o_target,
    output logic [31:0] o_value,
    output logic        o_done_res,
    output logic [2:0]  o_status
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    assign o_in_stall = full;

    dpcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push)
    );

    dpcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    dpcp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_update_valid (o_update_valid),
        .o_target       (o_target),
        .o_value        (o_value),
        .o_done_res     (o_done_res),
        .o_status       (o_status)
    );

endmodule

### sim/diag_page_counter_parser_tb.sv
// ----------------------------------------------------------------------------
// diag_page_counter_parser_tb
// Self-checking bench for the diagnostic page counter parser.
// ----------------------------------------------------------------------------
// Pages are fed one byte per transaction. A short directed table comes first.
// Random pages follow, mostly well formed with random content, plus broken
// ones: wrong page code, bad feature count or id, residual length, truncated,
// padded, short and noise pages. A behavioral parser in the bench predicts
// every counter update and page status. Each result is checked field by field
// in order. Both sides idle and stall at random, and the accepted page code is
// changed between phases.
module diag_page_counter_parser_tb import dpcp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic        upd;
        logic [3:0]  tgt;
        logic [31:0] val;
        logic        done;
        t_status     st;
    } t_counter_report;

    typedef struct packed {
        logic [7:0] data;
        logic       lst;
        logic       typed;
        t_status    st;
    } t_page_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_update_valid;
    logic [3:0]  o_target;
    logic [31:0] o_value;
    logic        o_done_res;
    logic [2:0]  o_status;

    // Parser state mirrored by the bench
    logic [7:0]  cfg_page_code;
    logic [16:0] pg_pos;
    logic [15:0] pg_len;
    logic [7:0]  pg_code;
    logic [15:0] recs_left;
    logic [2:0]  rec_idx;
    logic [15:0] rec_id;
    logic [15:0] rec_sub;
    logic [31:0] rec_val;
    logic [15:0] resid;
    t_status     pg_err;

    t_counter_report reports_due[$];
    t_page_row       dir_rows[$];
    logic [7:0]      page_q[$];
    int              err_cnt = 0;
    bit              in_idle_on = 1'b1;
    bit              out_idle_on = 1'b1;

    diag_page_counter_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_update_valid(o_update_valid),
        .o_target      (o_target),
        .o_value       (o_value),
        .o_done_res    (o_done_res),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic clear_page();
        pg_pos    = '0;
        pg_len    = '0;
        pg_code   = '0;
        recs_left = '0;
        rec_idx   = '0;
        rec_id    = '0;
        rec_sub   = '0;
        rec_val   = '0;
        resid     = '0;
        pg_err    = ST_OK;
    endtask

    task automatic flag_error(input t_status code);
        if (pg_err == ST_OK)
            pg_err = code;
    endtask

    // Advance the page state by one byte and work out the report it causes
    task automatic parse_page_byte(input logic [7:0] b, input logic lst,
                                   output bit has_rep, output t_counter_report rep);
        logic [16:0] pos;
        pos = pg_pos;
        rep = '0;
        case (pos)
            POS_PAGE_CODE: pg_code = b;
            POS_LEN_HI:    pg_len = {b, 8'h00};
            POS_LEN_LO: begin
                pg_len[7:0] = b;
                resid = pg_len - HDR_BYTES_AFTER_LEN;
            end
            POS_FC_HI:     if (b != 8'h00) flag_error(ST_FCOUNT);
            POS_FC_LO:     if (b != 8'h01) flag_error(ST_FCOUNT);
            POS_FID_HI,
            POS_FID_LO:    if (b != 8'h00) flag_error(ST_FID);
            POS_PC_HI: begin
                recs_left = {b, 8'h00};
                resid = resid - {b[4:0], 11'd0};
            end
            POS_PC_LO: begin
                recs_left[7:0] = b;
                resid = resid - {5'd0, b, 3'd0};
            end
            default: begin
                if (pos >= POS_FIRST_REC && recs_left != 16'd0) begin
                    case (rec_idx)
                        3'd0:    rec_id[15:8] = b;
                        3'd1:    rec_id[7:0] = b;
                        3'd2:    rec_sub[15:8] = b;
                        3'd3:    rec_sub[7:0] = b;
                        3'd4:    rec_val = {24'd0, b};
                        default: rec_val = {rec_val[23:0], b};
                    endcase
                    if (rec_idx == 3'd7) begin
                        if (pg_code == cfg_page_code && pg_err == ST_OK) begin
                            if (rec_id == 16'd0 && rec_sub == 16'd0) begin
                                rep.upd = 1'b1;
                            end else if (rec_id >= 16'd1 && rec_id <= MAX_COUNTER_ID &&
                                         rec_sub <= 16'd1) begin
                                rep.upd = 1'b1;
                                rep.tgt = 4'(2 * rec_id - 1 + rec_sub);
                            end
                        end
                        if (rep.upd)
                            rep.val = rec_val;
                        recs_left = recs_left - 16'd1;
                        rec_idx = '0;
                    end else begin
                        rec_idx = rec_idx + 3'd1;
                    end
                end
            end
        endcase

        if (pg_pos != POS_MAX)
            pg_pos = pg_pos + 17'd1;

        if (lst) begin
            rep.done = 1'b1;
            if (pg_pos != {1'b0, pg_len} + LEN_OVERHEAD)
                rep.st = ST_LENGTH;
            else if (pg_code != cfg_page_code)
                rep.st = ST_PAGE;
            else if (pos < POS_FC_LO || pg_err == ST_FCOUNT)
                rep.st = ST_FCOUNT;
            else if (pg_err != ST_OK)
                rep.st = pg_err;
            else if (resid != 16'd0)
                rep.st = ST_RESIDUAL;
            else
                rep.st = ST_OK;
            clear_page();
        end
        has_rep = rep.upd || lst;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input bit typed, input t_status typed_st);
        int              gap;
        bit              has_rep;
        t_counter_report rep;
        gap = in_idle_on ? $urandom_range(0, 17) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = lst;
        do @(posedge i_clk); while (o_in_stall);
        parse_page_byte(b, lst, has_rep, rep);
        if (typed) begin
            rep      = '0;
            rep.done = 1'b1;
            rep.st   = typed_st;
        end
        if (has_rep)
            reports_due.push_back(rep);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_page_code(input logic [7:0] code);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = code;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_page_code = code;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(input logic [7:0] data, input logic lst,
                           input bit typed, input t_status st);
        t_page_row row;
        row.data  = data;
        row.lst   = lst;
        row.typed = typed;
        row.st    = st;
        dir_rows.push_back(row);
    endtask

    task automatic push_random(input int n);
        repeat (n) page_q.push_back(8'($urandom));
    endtask

    // Well-formed page with n_rec records and pad bytes counted in the length
    task automatic build_page(input int n_rec, input int pad);
        logic [15:0] len;
        logic [31:0] v;
        len = 16'(22 + 8 * n_rec + pad);
        page_q.delete();
        page_q.push_back(cfg_page_code);
        push_random(1);
        page_q.push_back(len[15:8]);
        page_q.push_back(len[7:0]);
        push_random(12);
        page_q.push_back(8'h00);
        page_q.push_back(8'h01);
        page_q.push_back(8'h00);
        page_q.push_back(8'h00);
        push_random(3);
        page_q.push_back(8'(n_rec >> 8));
        page_q.push_back(8'(n_rec));
        push_random(1);
        repeat (n_rec) begin
            if ($urandom_range(0, 9) < 8) begin
                page_q.push_back(8'h00);
                page_q.push_back(8'($urandom_range(0, 5)));
            end else begin
                push_random(2);
            end
            if ($urandom_range(0, 9) < 8) begin
                page_q.push_back(8'h00);
                page_q.push_back(8'($urandom_range(0, 1)));
            end else begin
                push_random(2);
            end
            case ($urandom_range(0, 9))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            page_q.push_back(v[31:24]);
            page_q.push_back(v[23:16]);
            page_q.push_back(v[15:8]);
            page_q.push_back(v[7:0]);
        end
        push_random(pad);
    endtask

    task automatic send_page();
        for (int i = 0; i < page_q.size(); i++)
            send_byte(page_q[i], i == page_q.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic run_pages(input int n_bytes);
        int sent;
        int n_rec;
        int k;
        sent = 0;
        while (sent < n_bytes) begin
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            n_rec = $urandom_range(0, 4);
            build_page(n_rec, 0);
            case ($urandom_range(0, 19))
                0: page_q[0] = page_q[0] ^ 8'($urandom_range(1, 255));
                1: page_q[16 + $urandom_range(0, 1)] = 8'($urandom);
                2: page_q[18 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
                3: begin
                    // declare more length than the records fill
                    k = $urandom_range(1, 9);
                    build_page(n_rec, k);
                end
                4: page_q[24] = page_q[24] + 8'd1;
                5: begin
                    // cut the page, possibly inside a record
                    k = $urandom_range(1, page_q.size() - 1);
                    while (page_q.size() > k) page_q.pop_back();
                end
                6: push_random($urandom_range(1, 10));
                7: begin
                    // end before the feature count completes, length consistent
                    k = $urandom_range(4, 17);
                    while (page_q.size() > k) page_q.pop_back();
                    page_q[2] = 8'h00;
                    page_q[3] = 8'(k - 4);
                end
                8: begin
                    page_q.delete();
                    push_random($urandom_range(1, 40));
                end
                default: ;
            endcase
            send_page();
            sent += page_q.size();
        end
    endtask

    // Output side: stall before each transaction for a random count
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = out_idle_on ? $urandom_range(0, 17) : 0;
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_counter_report exp_rep;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected transaction target %0h value %0h status %0h",
                         $time, o_target, o_value, o_status);
                err_cnt++;
            end else begin
                exp_rep = reports_due.pop_front();
                check_field("update_valid", 32'(exp_rep.upd), 32'(o_update_valid));
                check_field("target", 32'(exp_rep.tgt), 32'(o_target));
                check_field("value", exp_rep.val, o_value);
                check_field("done_res", 32'(exp_rep.done), 32'(o_done_res));
                check_field("status", 32'(exp_rep.st), 32'(o_status));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        cfg_page_code = EXP_PAGE_RESET;
        clear_page();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_page_code(EXP_PAGE_RESET);

        // Single byte page: length fails
        add_row(8'hFF, 1'b1, 1'b1, ST_LENGTH);
        // Four bytes, length 0: ends before the feature count
        add_row(8'h82, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b1, 1'b1, ST_FCOUNT);
        // Four bytes, length 0, foreign page code
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'hFF, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b1, 1'b1, ST_PAGE);
        // Twenty bytes, length 16, feature id nonzero
        add_row(8'h82, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h10, 1'b0, 1'b0, ST_OK);
        for (int i = 0; i < 12; i++)
            add_row(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h01, 1'b0, 1'b0, ST_OK);
        add_row(8'h00, 1'b0, 1'b0, ST_OK);
        add_row(8'h01, 1'b1, 1'b1, ST_FID);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].st);

        run_pages(175);
        wait_idle();
        write_page_code(8'h00);
        run_pages(175);
        wait_idle();
        write_page_code(8'hFF);
        run_pages(175);
        wait_idle();
        write_page_code(8'($urandom));
        run_pages(175);

        wait_idle();
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dpcp_pkg.sv
hw/rtl/dpcp_front.sv
hw/rtl/dpcp_fifo.sv
hw/rtl/dpcp_back.sv
hw/rtl/diag_page_counter_parser.sv
sim/diag_page_counter_parser_tb.sv
